// ===== hw/rtl/blr_pkg.sv =====
package blr_pkg;

    // Field widths fixed by the command and pixel formats.
    localparam int COORD_W  = 6;
    localparam int COLOUR_W = 8;
    localparam int DIM_W    = 7;
    localparam int P_W      = 8;
    localparam int IN_W     = 4 * COORD_W + 3 * COLOUR_W;
    localparam int OUT_W    = 40;

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // A classified line command, ready for the walker.
    typedef struct packed {
        logic [COORD_W-1:0]    x0;
        logic [COORD_W-1:0]    y0;
        logic [COORD_W-1:0]    major;
        logic [COORD_W-1:0]    minor;
        logic                  steep;
        logic                  ydown;
        logic [3*COLOUR_W-1:0] colour;
    } cmd_t;

    // Occupancy flags of the command queue.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic {
        WALK_IDLE,
        WALK_RUN
    } walk_state_t;

endpackage

// ===== hw/rtl/blr_front.sv =====
module blr_front
(
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // start_y, start_x, end_y, end_x, colour_red, colour_green, colour_blue
    input  logic [blr_pkg::IN_W-1:0]    s_axis_tdata,
    input  blr_pkg::q_status_t          q_status,
    output logic                        push,
    output blr_pkg::cmd_t               cmd
);

    logic [blr_pkg::COORD_W-1:0] sy, sx, ey, ex;
    logic [blr_pkg::COORD_W-1:0] dx, dy;
    logic                        shallow;
    logic                        falling;
    logic                        swap;

    // Unpack the endpoints.
    assign sy = s_axis_tdata[5:0];
    assign sx = s_axis_tdata[11:6];
    assign ey = s_axis_tdata[17:12];
    assign ex = s_axis_tdata[23:18];

    // Classify the line and pick the endpoint that the walk starts from.
    always_comb
    begin
        dx      = (ex > sx) ? (ex - sx) : (sx - ex);
        dy      = (ey > sy) ? (ey - sy) : (sy - ey);
        shallow = (dx > dy);
        falling = ((ey < sy) && (ex > sx)) || ((ey > sy) && (ex < sx));
        // Shallow lines and falling lines start at the smaller x, the rest at the smaller y.
        swap    = (shallow || falling) ? (sx > ex) : (sy > ey);

        cmd.x0     = swap ? ex : sx;
        cmd.y0     = swap ? ey : sy;
        cmd.major  = shallow ? dx : dy;
        cmd.minor  = shallow ? dy : dx;
        cmd.steep  = !shallow;
        cmd.ydown  = falling;
        cmd.colour = s_axis_tdata[47:24];
    end

    // Take a command whenever the queue has room.
    assign s_axis_tready = !q_status.full;
    assign push          = s_axis_tvalid && s_axis_tready;

endmodule

// ===== hw/rtl/blr_queue.sv =====
module blr_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  blr_pkg::cmd_t      wdata,
    input  logic               pop,
    output blr_pkg::cmd_t      rdata,
    output blr_pkg::q_status_t status
);

    blr_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Storage for the queued commands.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata        = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

endmodule

// ===== hw/rtl/blr_walk.sv =====
module blr_walk
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  blr_pkg::cmd_t                 cmd,
    input  blr_pkg::q_status_t            q_status,
    output logic                          pop,
    input  logic [blr_pkg::DIM_W-1:0]     width,
    input  logic [blr_pkg::DIM_W-1:0]     height,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pixel_row, pixel_col, red, green, blue, zero padding
    output logic [blr_pkg::OUT_W-1:0]     m_axis_tdata,
    // visible
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast
);

    blr_pkg::walk_state_t               state_reg, state_next;
    logic [blr_pkg::COORD_W-1:0]        x_reg, x_next;
    logic [blr_pkg::COORD_W-1:0]        y_reg, y_next;
    logic signed [blr_pkg::P_W-1:0]     p_reg, p_next;
    logic [blr_pkg::COORD_W-1:0]        cnt_reg, cnt_next;
    logic [blr_pkg::DIM_W-1:0]          inc_a_reg, inc_a_next;
    logic signed [blr_pkg::P_W-1:0]     inc_b_reg, inc_b_next;
    logic                               steep_reg, steep_next;
    logic                               ydown_reg, ydown_next;
    logic [3*blr_pkg::COLOUR_W-1:0]     colour_reg, colour_next;
    logic                               out_valid_reg, out_valid_next;
    logic [blr_pkg::OUT_W-1:0]          out_data_reg, out_data_next;
    logic                               out_vis_reg, out_vis_next;
    logic                               out_last_reg, out_last_next;

    logic                               emit;
    logic                               vis;
    logic [blr_pkg::DIM_W-1:0]          row_full;
    logic [blr_pkg::COORD_W-1:0]        row;
    logic                               p_ge;
    logic [blr_pkg::COORD_W-1:0]        y_step;

    // Point visibility and flipped row.
    always_comb
    begin
        vis      = ({1'b0, y_reg} < height) && ({1'b0, x_reg} < width);
        row_full = height - 7'd1 - {1'b0, y_reg};
        row      = vis ? row_full[blr_pkg::COORD_W-1:0] : '0;
        p_ge     = !p_reg[blr_pkg::P_W-1];
        y_step   = ydown_reg ? y_reg - 6'd1 : y_reg + 6'd1;
    end

    assign emit = (state_reg == blr_pkg::WALK_RUN) && (!out_valid_reg || m_axis_tready);

    // Sequencer: load a command, then step one point per free output slot.
    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        p_next         = p_reg;
        cnt_next       = cnt_reg;
        inc_a_next     = inc_a_reg;
        inc_b_next     = inc_b_reg;
        steep_next     = steep_reg;
        ydown_next     = ydown_reg;
        colour_next    = colour_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_vis_next   = out_vis_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;

        unique case (state_reg)
            blr_pkg::WALK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop         = 1'b1;
                    x_next      = cmd.x0;
                    y_next      = cmd.y0;
                    cnt_next    = cmd.major;
                    p_next      = $signed({1'b0, cmd.minor, 1'b0}) - $signed({2'b00, cmd.major});
                    inc_a_next  = {cmd.minor, 1'b0};
                    inc_b_next  = $signed({1'b0, cmd.minor, 1'b0})
                                - $signed({1'b0, cmd.major, 1'b0});
                    steep_next  = cmd.steep;
                    ydown_next  = cmd.ydown;
                    colour_next = cmd.colour;
                    state_next  = blr_pkg::WALK_RUN;
                end
            end
            blr_pkg::WALK_RUN:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0000, colour_reg[23:16], colour_reg[15:8],
                                      colour_reg[7:0], x_reg, row};
                    out_vis_next   = vis;
                    out_last_next  = (cnt_reg == '0);
                    cnt_next       = cnt_reg - 6'd1;
                    // Major axis always steps; minor axis steps on a non-negative error.
                    if (steep_reg)
                    begin
                        y_next = y_step;
                        if (p_ge)
                        begin
                            x_next = x_reg + 6'd1;
                        end
                    end
                    else
                    begin
                        x_next = x_reg + 6'd1;
                        if (p_ge)
                        begin
                            y_next = y_step;
                        end
                    end
                    p_next = p_ge ? (p_reg + inc_b_reg) : (p_reg + $signed({1'b0, inc_a_reg}));
                    if (cnt_reg == '0)
                    begin
                        state_next = blr_pkg::WALK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = blr_pkg::WALK_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blr_pkg::WALK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walk and output payload registers.
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        p_reg        <= p_next;
        cnt_reg      <= cnt_next;
        inc_a_reg    <= inc_a_next;
        inc_b_reg    <= inc_b_next;
        steep_reg    <= steep_next;
        ydown_reg    <= ydown_next;
        colour_reg   <= colour_next;
        out_data_reg <= out_data_next;
        out_vis_reg  <= out_vis_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_vis_reg;
    assign m_axis_tlast  = out_last_reg;

    // A clipped point always carries row zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_vis_reg) |-> (out_data_reg[5:0] == 6'd0))
        else $error("clipped point with non-zero row");

    // Commands leave the queue only while the walker is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == blr_pkg::WALK_IDLE))
        else $error("queue popped during a walk");

    // Each emitted point that is not the last counts the remainder down by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (cnt_reg != '0)) |=> (cnt_reg == $past(cnt_reg) - 6'd1))
        else $error("point count did not step");

    // The walk ends exactly when the last point is emitted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (cnt_reg == '0)) |=> (state_reg == blr_pkg::WALK_IDLE) && m_axis_tlast)
        else $error("walk did not end on the last point");

endmodule

// ===== hw/rtl/bresenham_line_rasterizer_unit.sv =====
// Line rasteriser: turns one line command into a stream of pixel writes.
// Input channel s_axis carries a command (two endpoints of 0..63 and an RGB
// colour); output channel m_axis carries one pixel write per point, with
// tuser flagging a point inside the screen and tlast marking the final point.
// The cfg channel writes screen_width (index 0) and screen_height (index 1);
// values above SCREEN_DIM are held at SCREEN_DIM, and writes are always taken.
// Reset sets both registers to SCREEN_DIM and empties the pipeline.
// A command is classified in the front end and lands in a two-entry queue, so
// up to two commands are taken while a line is still being drawn.
// An accepted command passes through the queue and the walker's command registers
// before its first point reaches the output register. The walker loads the command,
// then produces one point per cycle while the output is free, at most 64 per line.
// When the receiver holds tready low, the output register keeps its point and
// the walker waits; once the queue is full, s_axis_tready drops.
module bresenham_line_rasterizer_unit
#(
    parameter int SCREEN_DIM = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // start_y, start_x, end_y, end_x, colour_red, colour_green, colour_blue
    input  logic [blr_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pixel_row, pixel_col, red, green, blue, zero padding
    output logic [blr_pkg::OUT_W-1:0]     m_axis_tdata,
    // visible
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [blr_pkg::DIM_W-1:0]     cfg_data
);

    localparam logic [blr_pkg::DIM_W-1:0] DIM_MAX = blr_pkg::DIM_W'(SCREEN_DIM);

    logic [blr_pkg::DIM_W-1:0] width_reg;
    logic [blr_pkg::DIM_W-1:0] height_reg;
    logic [blr_pkg::DIM_W-1:0] cfg_sat;
    logic                      push;
    logic                      pop;
    blr_pkg::cmd_t             front_cmd;
    blr_pkg::cmd_t             queue_cmd;
    blr_pkg::q_status_t        q_status;

    // Screen size registers, saturated to the largest screen.
    assign cfg_ready = 1'b1;
    assign cfg_sat   = (cfg_data > DIM_MAX) ? DIM_MAX : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_MAX;
            height_reg <= DIM_MAX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                blr_pkg::CFG_WIDTH:  width_reg  <= cfg_sat;
                blr_pkg::CFG_HEIGHT: height_reg <= cfg_sat;
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    blr_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_status      (q_status),
        .push          (push),
        .cmd           (front_cmd)
    );

    blr_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (front_cmd),
        .pop    (pop),
        .rdata  (queue_cmd),
        .status (q_status)
    );

    blr_walk u_walk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (queue_cmd),
        .q_status      (q_status),
        .pop           (pop),
        .width         (width_reg),
        .height        (height_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
